// ----- rtl/cebms_pkg.sv -----
package cebms_pkg;

  // Instruction bytes
  localparam logic [7:0] OP_EX_DE_HL   = 8'hEB;
  localparam logic [7:0] OP_EX_AF_AF   = 8'h08;
  localparam logic [7:0] OP_EXX        = 8'hD9;
  localparam logic [7:0] OP_EX_SP_HL   = 8'hE3;
  localparam logic [7:0] PFX_IX        = 8'hDD;
  localparam logic [7:0] PFX_IY        = 8'hFD;
  localparam logic [7:0] PFX_ED        = 8'hED;
  localparam logic [7:0] BLK_MASK      = 8'hE6;
  localparam logic [7:0] BLK_MATCH     = 8'hA0;

  // Bit positions inside the second byte of a block instruction
  localparam int BLK_BIT_SEARCH = 0;
  localparam int BLK_BIT_DOWN   = 3;
  localparam int BLK_BIT_REPEAT = 4;

  // Flag bit positions in F
  localparam int FLAG_S  = 7;
  localparam int FLAG_Z  = 6;
  localparam int FLAG_H  = 4;
  localparam int FLAG_PV = 2;
  localparam int FLAG_N  = 1;

  // Emulated cycle counts
  localparam logic [4:0] CYC_NONE     = 5'd0;
  localparam logic [4:0] CYC_EX       = 5'd4;
  localparam logic [4:0] CYC_BLK_DONE = 5'd16;
  localparam logic [4:0] CYC_EX_SP_HL = 5'd19;
  localparam logic [4:0] CYC_BLK_RPT  = 5'd21;
  localparam logic [4:0] CYC_EX_SP_IX = 5'd23;

  typedef enum logic {
    KIND_EXEC = 1'b0,
    KIND_LOAD = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    PAIR_AF     = 4'd0,
    PAIR_BC     = 4'd1,
    PAIR_DE     = 4'd2,
    PAIR_HL     = 4'd3,
    PAIR_AF_ALT = 4'd4,
    PAIR_BC_ALT = 4'd5,
    PAIR_DE_ALT = 4'd6,
    PAIR_HL_ALT = 4'd7,
    PAIR_IX     = 4'd8,
    PAIR_IY     = 4'd9
  } pair_idx_t;

  typedef struct packed {
    logic [15:0] af;
    logic [15:0] bc;
    logic [15:0] de;
    logic [15:0] hl;
    logic [15:0] af_alt;
    logic [15:0] bc_alt;
    logic [15:0] de_alt;
    logic [15:0] hl_alt;
    logic [15:0] ix;
    logic [15:0] iy;
  } regs_t;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  prefix_byte;
    logic [7:0]  second_byte;
    logic [7:0]  read_byte_lo;
    logic [7:0]  read_byte_hi;
    logic [3:0]  pair_index;
    logic [15:0] pair_value;
  } in_item_t;

  typedef struct packed {
    logic        recognized;
    logic [1:0]  pc_advance;
    logic [4:0]  cycles;
    logic [1:0]  write_count;
    logic [15:0] write_address;
    logic [15:0] write_data;
    logic [15:0] af_value;
    logic [15:0] bc_value;
    logic [15:0] de_value;
    logic [15:0] hl_value;
    logic [15:0] ix_value;
    logic [15:0] iy_value;
  } out_item_t;

endpackage

// ----- rtl/cebms_if.sv -----
interface cebms_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  prefix_byte;
  logic [7:0]  second_byte;
  logic [7:0]  read_byte_lo;
  logic [7:0]  read_byte_hi;
  logic [3:0]  pair_index;
  logic [15:0] pair_value;

  modport source (
    output valid, opcode, prefix_byte, second_byte, read_byte_lo, read_byte_hi,
           pair_index, pair_value,
    input  ready
  );
  modport sink (
    input  valid, opcode, prefix_byte, second_byte, read_byte_lo, read_byte_hi,
           pair_index, pair_value,
    output ready
  );
endinterface

interface cebms_out_if;
  logic        valid;
  logic        ready;
  logic        recognized;
  logic [1:0]  pc_advance;
  logic [4:0]  cycles;
  logic [1:0]  write_count;
  logic [15:0] write_address;
  logic [15:0] write_data;
  logic [15:0] af_value;
  logic [15:0] bc_value;
  logic [15:0] de_value;
  logic [15:0] hl_value;
  logic [15:0] ix_value;
  logic [15:0] iy_value;

  modport source (
    output valid, recognized, pc_advance, cycles, write_count, write_address,
           write_data, af_value, bc_value, de_value, hl_value, ix_value, iy_value,
    input  ready
  );
  modport sink (
    input  valid, recognized, pc_advance, cycles, write_count, write_address,
           write_data, af_value, bc_value, de_value, hl_value, ix_value, iy_value,
    output ready
  );
endinterface

// ----- rtl/cpu_exchange_block_move_search_unit.sv -----
// Exchange / block transfer / block search execution unit (Z80 style).
//
// Input channel in_ch (valid/ready): one item is either an instruction to
// execute (prefix and second byte plus the memory bytes at the operand
// address) or a load of one register pair. Result channel out_ch carries
// one item per input item: recognition, PC advance, emulated cycle count,
// up to two bytes to write to memory and the register pairs after the step.
// cfg_wr_en/cfg_wr_data set the stack pointer used by EX (SP),rr; write it
// only while no item is in flight.
//
// An accepted item is held in the input register, decoded from there,
// and its result is loaded into the output register once that is free
// or being emptied. Throughput is one item per clock while the receiver
// keeps up; the single decode-and-update stage between the input and
// output registers sets that figure; the register file is updated at the
// same edge that loads the result, so the next item sees the new state.
//
// Reset (rst_n low, synchronous) clears all register pairs, IX, IY, the
// stack pointer and both valid flags. When the receiver stalls, the result
// holds in the output register, one more item may wait in the input
// register, and in_ch.ready drops only once both are full.
module cpu_exchange_block_move_search_unit (
  input  logic                clk,
  input  logic                rst_n,
  cebms_in_if.sink            in_ch,
  cebms_out_if.source         out_ch,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data
);

  logic                 s0_valid_r;
  cebms_pkg::in_item_t  s0_item_r;
  logic                 out_valid_r;
  cebms_pkg::out_item_t out_item_r;
  cebms_pkg::out_item_t out_item_nxt;
  cebms_pkg::regs_t     regs_r;
  cebms_pkg::regs_t     regs_nxt;
  logic [15:0]          sp_r;

  logic s0_adv;
  logic in_ready;

  // Block instruction helpers
  logic        blk_down;
  logic        blk_repeat;
  logic        blk_again;
  logic [15:0] bc_dec;
  logic        bc_nz;
  logic [7:0]  acc;
  logic [7:0]  diff;
  logic [7:0]  flags;
  logic [15:0] mem_word;

  // Move the input item forward whenever the output register is free or
  // being emptied this cycle.
  assign s0_adv   = s0_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s0_valid_r || s0_adv;
  assign in_ch.ready = in_ready;

  always_comb begin
    regs_nxt   = regs_r;
    out_item_nxt = '0;
    mem_word   = {s0_item_r.read_byte_hi, s0_item_r.read_byte_lo};
    blk_down   = s0_item_r.second_byte[cebms_pkg::BLK_BIT_DOWN];
    blk_repeat = s0_item_r.second_byte[cebms_pkg::BLK_BIT_REPEAT];
    bc_dec     = regs_r.bc - 16'd1;
    bc_nz      = (bc_dec != 16'd0);
    acc        = regs_r.af[15:8];
    diff       = acc - s0_item_r.read_byte_lo;
    flags      = regs_r.af[7:0];
    blk_again  = 1'b0;

    if (s0_item_r.opcode == cebms_pkg::KIND_LOAD) begin
      out_item_nxt.recognized = 1'b1;
      unique case (cebms_pkg::pair_idx_t'(s0_item_r.pair_index))
        cebms_pkg::PAIR_AF:     regs_nxt.af     = s0_item_r.pair_value;
        cebms_pkg::PAIR_BC:     regs_nxt.bc     = s0_item_r.pair_value;
        cebms_pkg::PAIR_DE:     regs_nxt.de     = s0_item_r.pair_value;
        cebms_pkg::PAIR_HL:     regs_nxt.hl     = s0_item_r.pair_value;
        cebms_pkg::PAIR_AF_ALT: regs_nxt.af_alt = s0_item_r.pair_value;
        cebms_pkg::PAIR_BC_ALT: regs_nxt.bc_alt = s0_item_r.pair_value;
        cebms_pkg::PAIR_DE_ALT: regs_nxt.de_alt = s0_item_r.pair_value;
        cebms_pkg::PAIR_HL_ALT: regs_nxt.hl_alt = s0_item_r.pair_value;
        cebms_pkg::PAIR_IX:     regs_nxt.ix     = s0_item_r.pair_value;
        cebms_pkg::PAIR_IY:     regs_nxt.iy     = s0_item_r.pair_value;
        default:                out_item_nxt.recognized = 1'b0;
      endcase
    end else if (s0_item_r.prefix_byte == cebms_pkg::OP_EX_DE_HL) begin
      regs_nxt.de = regs_r.hl;
      regs_nxt.hl = regs_r.de;
      out_item_nxt.recognized = 1'b1;
      out_item_nxt.pc_advance = 2'd1;
      out_item_nxt.cycles     = cebms_pkg::CYC_EX;
    end else if (s0_item_r.prefix_byte == cebms_pkg::OP_EX_AF_AF) begin
      regs_nxt.af     = regs_r.af_alt;
      regs_nxt.af_alt = regs_r.af;
      out_item_nxt.recognized = 1'b1;
      out_item_nxt.pc_advance = 2'd1;
      out_item_nxt.cycles     = cebms_pkg::CYC_EX;
    end else if (s0_item_r.prefix_byte == cebms_pkg::OP_EXX) begin
      regs_nxt.bc     = regs_r.bc_alt;
      regs_nxt.de     = regs_r.de_alt;
      regs_nxt.hl     = regs_r.hl_alt;
      regs_nxt.bc_alt = regs_r.bc;
      regs_nxt.de_alt = regs_r.de;
      regs_nxt.hl_alt = regs_r.hl;
      out_item_nxt.recognized = 1'b1;
      out_item_nxt.pc_advance = 2'd1;
      out_item_nxt.cycles     = cebms_pkg::CYC_EX;
    end else if (s0_item_r.prefix_byte == cebms_pkg::OP_EX_SP_HL) begin
      regs_nxt.hl = mem_word;
      out_item_nxt.write_data    = regs_r.hl;
      out_item_nxt.write_address = sp_r;
      out_item_nxt.write_count   = 2'd2;
      out_item_nxt.recognized    = 1'b1;
      out_item_nxt.pc_advance    = 2'd1;
      out_item_nxt.cycles        = cebms_pkg::CYC_EX_SP_HL;
    end else if ((s0_item_r.prefix_byte == cebms_pkg::PFX_IX ||
                  s0_item_r.prefix_byte == cebms_pkg::PFX_IY) &&
                 s0_item_r.second_byte == cebms_pkg::OP_EX_SP_HL) begin
      // EX (SP),IX / EX (SP),IY
      if (s0_item_r.prefix_byte == cebms_pkg::PFX_IX) begin
        out_item_nxt.write_data = regs_r.ix;
        regs_nxt.ix = mem_word;
      end else begin
        out_item_nxt.write_data = regs_r.iy;
        regs_nxt.iy = mem_word;
      end
      out_item_nxt.write_address = sp_r;
      out_item_nxt.write_count   = 2'd2;
      out_item_nxt.recognized    = 1'b1;
      out_item_nxt.pc_advance    = 2'd2;
      out_item_nxt.cycles        = cebms_pkg::CYC_EX_SP_IX;
    end else if (s0_item_r.prefix_byte == cebms_pkg::PFX_ED &&
                 (s0_item_r.second_byte & cebms_pkg::BLK_MASK) == cebms_pkg::BLK_MATCH) begin
      // One step of LDI/LDD/CPI/CPD and their repeat forms
      regs_nxt.bc = bc_dec;
      regs_nxt.hl = blk_down ? (regs_r.hl - 16'd1) : (regs_r.hl + 16'd1);
      flags[cebms_pkg::FLAG_PV] = bc_nz;
      if (!s0_item_r.second_byte[cebms_pkg::BLK_BIT_SEARCH]) begin
        regs_nxt.de = blk_down ? (regs_r.de - 16'd1) : (regs_r.de + 16'd1);
        flags[cebms_pkg::FLAG_H] = 1'b0;
        flags[cebms_pkg::FLAG_N] = 1'b0;
        out_item_nxt.write_address = regs_r.de;
        out_item_nxt.write_data    = {8'd0, s0_item_r.read_byte_lo};
        out_item_nxt.write_count   = 2'd1;
        blk_again = blk_repeat && bc_nz;
      end else begin
        flags[cebms_pkg::FLAG_S] = diff[7];
        flags[cebms_pkg::FLAG_Z] = (diff == 8'd0);
        flags[cebms_pkg::FLAG_H] = (acc[3:0] < s0_item_r.read_byte_lo[3:0]);
        flags[cebms_pkg::FLAG_N] = 1'b1;
        blk_again = blk_repeat && bc_nz && (diff != 8'd0);
      end
      regs_nxt.af = {acc, flags};
      out_item_nxt.recognized = 1'b1;
      out_item_nxt.pc_advance = blk_again ? 2'd0 : 2'd2;
      out_item_nxt.cycles     = blk_again ? cebms_pkg::CYC_BLK_RPT : cebms_pkg::CYC_BLK_DONE;
    end

    out_item_nxt.af_value = regs_nxt.af;
    out_item_nxt.bc_value = regs_nxt.bc;
    out_item_nxt.de_value = regs_nxt.de;
    out_item_nxt.hl_value = regs_nxt.hl;
    out_item_nxt.ix_value = regs_nxt.ix;
    out_item_nxt.iy_value = regs_nxt.iy;
  end

  // Control state, architectural registers and the stack pointer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      regs_r      <= '0;
      sp_r        <= '0;
    end else begin
      if (in_ready) begin
        s0_valid_r <= in_ch.valid;
      end
      if (s0_adv) begin
        out_valid_r <= 1'b1;
        regs_r      <= regs_nxt;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr_en) begin
        sp_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers: capture on accept, hold while stalled
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ready) begin
      s0_item_r <= '{opcode:       in_ch.opcode,
                     prefix_byte:  in_ch.prefix_byte,
                     second_byte:  in_ch.second_byte,
                     read_byte_lo: in_ch.read_byte_lo,
                     read_byte_hi: in_ch.read_byte_hi,
                     pair_index:   in_ch.pair_index,
                     pair_value:   in_ch.pair_value};
    end
    if (s0_adv) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.recognized    = out_item_r.recognized;
  assign out_ch.pc_advance    = out_item_r.pc_advance;
  assign out_ch.cycles        = out_item_r.cycles;
  assign out_ch.write_count   = out_item_r.write_count;
  assign out_ch.write_address = out_item_r.write_address;
  assign out_ch.write_data    = out_item_r.write_data;
  assign out_ch.af_value      = out_item_r.af_value;
  assign out_ch.bc_value      = out_item_r.bc_value;
  assign out_ch.de_value      = out_item_r.de_value;
  assign out_ch.hl_value      = out_item_r.hl_value;
  assign out_ch.ix_value      = out_item_r.ix_value;
  assign out_ch.iy_value      = out_item_r.iy_value;

endmodule

// ----- rtl/cebms_chk.sv -----
module cebms_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_recognized,
  input logic [1:0]  out_pc_advance,
  input logic [4:0]  out_cycles,
  input logic [1:0]  out_write_count,
  input logic [15:0] out_write_address,
  input logic [15:0] out_write_data
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_write_address) &&
                                $stable(out_write_data) && $stable(out_cycles))
    else $error("result changed while stalled");

  // Unrecognized items report no work
  a_unrec_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_recognized |->
      out_pc_advance == 2'd0 && out_cycles == 5'd0 && out_write_count == 2'd0)
    else $error("unrecognized item reports work");

  // Two-byte writes come only from stack exchanges
  a_stack_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_count == 2'd2 |->
      (out_cycles == 5'd19 && out_pc_advance == 2'd1) ||
      (out_cycles == 5'd23 && out_pc_advance == 2'd2))
    else $error("two-byte write with wrong timing");

  // A recognized item without advance is a load or a continuing repeat
  a_repeat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_recognized && out_pc_advance == 2'd0 |->
      out_cycles == 5'd0 || out_cycles == 5'd21)
    else $error("zero advance with wrong cycle count");

  // Reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind cpu_exchange_block_move_search_unit cebms_chk u_cebms_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_recognized    (out_ch.recognized),
  .out_pc_advance    (out_ch.pc_advance),
  .out_cycles        (out_ch.cycles),
  .out_write_count   (out_ch.write_count),
  .out_write_address (out_ch.write_address),
  .out_write_data    (out_ch.write_data)
);

// ----- dv/cpu_exchange_block_move_search_unit_test.sv -----
module cpu_exchange_block_move_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Keep a shadow copy of the register file, IX, IY and the stack pointer.
  // Advance it once per accepted item and queue the result it must produce.
  class exchange_unit_tracker;
    localparam int R_A = 0;
    localparam int R_F = 1;
    localparam int R_B = 2;
    localparam int R_C = 3;
    localparam int R_D = 4;
    localparam int R_E = 5;
    localparam int R_H = 6;
    localparam int R_L = 7;
    localparam int ALT = 8;

    logic [7:0]            regs [16];
    logic [15:0]           ix_reg;
    logic [15:0]           iy_reg;
    logic [15:0]           sp_reg;
    cebms_pkg::out_item_t  step_results [$];
    int                    errors;
    int                    n_checked;
    int                    n_loads;
    int                    n_stack;
    int                    n_repeats;
    int                    n_unknown;

    function new();
      foreach (regs[i]) regs[i] = 8'h00;
      ix_reg = '0;
      iy_reg = '0;
      sp_reg = '0;
    endfunction

    function logic [15:0] pair_of(int hi);
      return {regs[hi], regs[hi + 1]};
    endfunction

    function void put_pair(int hi, logic [15:0] v);
      regs[hi]     = v[15:8];
      regs[hi + 1] = v[7:0];
    endfunction

    function void swap_bytes(int i, int j);
      logic [7:0] t;
      t       = regs[i];
      regs[i] = regs[j];
      regs[j] = t;
    endfunction

    function logic [7:0] accumulator();
      return regs[R_A];
    endfunction

    function int pending();
      return step_results.size();
    endfunction

    // Execute one item on the shadow state and return what the unit reports.
    function cebms_pkg::out_item_t execute_item(cebms_pkg::in_item_t it);
      cebms_pkg::out_item_t r;
      logic [15:0] mem_word;
      logic [15:0] hl;
      logic [15:0] de;
      logic [15:0] bc;
      logic [7:0]  acc;
      logic [7:0]  diff;
      logic        down;
      logic        rpt;
      logic        again;
      r        = '0;
      mem_word = {it.read_byte_hi, it.read_byte_lo};
      if (cebms_pkg::kind_t'(it.opcode) == cebms_pkg::KIND_LOAD) begin
        n_loads++;
        r.recognized = 1'b1;
        case (it.pair_index)
          cebms_pkg::PAIR_AF:     put_pair(R_A, it.pair_value);
          cebms_pkg::PAIR_BC:     put_pair(R_B, it.pair_value);
          cebms_pkg::PAIR_DE:     put_pair(R_D, it.pair_value);
          cebms_pkg::PAIR_HL:     put_pair(R_H, it.pair_value);
          cebms_pkg::PAIR_AF_ALT: put_pair(R_A + ALT, it.pair_value);
          cebms_pkg::PAIR_BC_ALT: put_pair(R_B + ALT, it.pair_value);
          cebms_pkg::PAIR_DE_ALT: put_pair(R_D + ALT, it.pair_value);
          cebms_pkg::PAIR_HL_ALT: put_pair(R_H + ALT, it.pair_value);
          cebms_pkg::PAIR_IX:     ix_reg = it.pair_value;
          cebms_pkg::PAIR_IY:     iy_reg = it.pair_value;
          default:                r.recognized = 1'b0;
        endcase
      end else if (it.prefix_byte == cebms_pkg::OP_EX_DE_HL) begin
        swap_bytes(R_D, R_H);
        swap_bytes(R_E, R_L);
        r.recognized = 1'b1;
        r.pc_advance = 2'd1;
        r.cycles     = cebms_pkg::CYC_EX;
      end else if (it.prefix_byte == cebms_pkg::OP_EX_AF_AF) begin
        swap_bytes(R_A, R_A + ALT);
        swap_bytes(R_F, R_F + ALT);
        r.recognized = 1'b1;
        r.pc_advance = 2'd1;
        r.cycles     = cebms_pkg::CYC_EX;
      end else if (it.prefix_byte == cebms_pkg::OP_EXX) begin
        for (int i = R_B; i <= R_L; i++) swap_bytes(i, i + ALT);
        r.recognized = 1'b1;
        r.pc_advance = 2'd1;
        r.cycles     = cebms_pkg::CYC_EX;
      end else if (it.prefix_byte == cebms_pkg::OP_EX_SP_HL) begin
        n_stack++;
        r.write_data = pair_of(R_H);
        put_pair(R_H, mem_word);
        r.write_address = sp_reg;
        r.write_count   = 2'd2;
        r.recognized    = 1'b1;
        r.pc_advance    = 2'd1;
        r.cycles        = cebms_pkg::CYC_EX_SP_HL;
      end else if ((it.prefix_byte == cebms_pkg::PFX_IX ||
                    it.prefix_byte == cebms_pkg::PFX_IY) &&
                   it.second_byte == cebms_pkg::OP_EX_SP_HL) begin
        n_stack++;
        if (it.prefix_byte == cebms_pkg::PFX_IX) begin
          r.write_data = ix_reg;
          ix_reg       = mem_word;
        end else begin
          r.write_data = iy_reg;
          iy_reg       = mem_word;
        end
        r.write_address = sp_reg;
        r.write_count   = 2'd2;
        r.recognized    = 1'b1;
        r.pc_advance    = 2'd2;
        r.cycles        = cebms_pkg::CYC_EX_SP_IX;
      end else if (it.prefix_byte == cebms_pkg::PFX_ED &&
                   (it.second_byte & cebms_pkg::BLK_MASK) == cebms_pkg::BLK_MATCH) begin
        down = it.second_byte[cebms_pkg::BLK_BIT_DOWN];
        rpt  = it.second_byte[cebms_pkg::BLK_BIT_REPEAT];
        hl   = pair_of(R_H);
        bc   = pair_of(R_B) - 16'd1;
        put_pair(R_H, down ? hl - 16'd1 : hl + 16'd1);
        put_pair(R_B, bc);
        regs[R_F][cebms_pkg::FLAG_PV] = (bc != 16'd0);
        if (!it.second_byte[cebms_pkg::BLK_BIT_SEARCH]) begin
          de              = pair_of(R_D);
          r.write_address = de;
          r.write_data    = {8'h00, it.read_byte_lo};
          r.write_count   = 2'd1;
          put_pair(R_D, down ? de - 16'd1 : de + 16'd1);
          regs[R_F][cebms_pkg::FLAG_H] = 1'b0;
          regs[R_F][cebms_pkg::FLAG_N] = 1'b0;
          again = rpt && bc != 16'd0;
        end else begin
          acc  = regs[R_A];
          diff = acc - it.read_byte_lo;
          regs[R_F][cebms_pkg::FLAG_S] = diff[7];
          regs[R_F][cebms_pkg::FLAG_Z] = (diff == 8'h00);
          regs[R_F][cebms_pkg::FLAG_H] = (acc[3:0] < it.read_byte_lo[3:0]);
          regs[R_F][cebms_pkg::FLAG_N] = 1'b1;
          again = rpt && bc != 16'd0 && diff != 8'h00;
        end
        if (again) n_repeats++;
        r.recognized = 1'b1;
        r.pc_advance = again ? 2'd0 : 2'd2;
        r.cycles     = again ? cebms_pkg::CYC_BLK_RPT : cebms_pkg::CYC_BLK_DONE;
      end else begin
        n_unknown++;
      end
      r.af_value = pair_of(R_A);
      r.bc_value = pair_of(R_B);
      r.de_value = pair_of(R_D);
      r.hl_value = pair_of(R_H);
      r.ix_value = ix_reg;
      r.iy_value = iy_reg;
      return r;
    endfunction

    function void note_accepted(cebms_pkg::in_item_t it);
      step_results.push_back(execute_item(it));
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      errors++;
    endtask

    task compare(string field, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %h, want %h", n_checked, field, got, want));
    endtask

    task check_result(cebms_pkg::out_item_t got);
      cebms_pkg::out_item_t want;
      if (step_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing outstanding", n_checked));
      end else begin
        want = step_results.pop_front();
        compare("recognized", 16'(got.recognized), 16'(want.recognized));
        compare("pc_advance", 16'(got.pc_advance), 16'(want.pc_advance));
        compare("cycles", 16'(got.cycles), 16'(want.cycles));
        compare("write_count", 16'(got.write_count), 16'(want.write_count));
        compare("write_address", got.write_address, want.write_address);
        compare("write_data", got.write_data, want.write_data);
        compare("af_value", got.af_value, want.af_value);
        compare("bc_value", got.bc_value, want.bc_value);
        compare("de_value", got.de_value, want.de_value);
        compare("hl_value", got.hl_value, want.hl_value);
        compare("ix_value", got.ix_value, want.ix_value);
        compare("iy_value", got.iy_value, want.iy_value);
      end
      n_checked++;
    endtask
  endclass

  // Give up after this many cycles in which neither channel moves an item.
  localparam int STALL_LIMIT = 500;
  // Length of the one long receiver hold-off.
  localparam int LONG_HOLD   = 60;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  cebms_in_if  in_ch ();
  cebms_out_if out_ch ();

  exchange_unit_tracker tracker = new();

  int items_offered;
  bit tx_idle_en;
  bit rx_idle_en;
  bit long_hold_req;
  int quiet_cycles;

  cpu_exchange_block_move_search_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Sample both channels at the rising edge. Inputs only move on the
  // falling edge, so the values seen here are the ones the unit latched.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_accepted({in_ch.opcode, in_ch.prefix_byte, in_ch.second_byte,
                               in_ch.read_byte_lo, in_ch.read_byte_hi,
                               in_ch.pair_index, in_ch.pair_value});
      if (out_ch.valid && out_ch.ready)
        tracker.check_result({out_ch.recognized, out_ch.pc_advance, out_ch.cycles,
                              out_ch.write_count, out_ch.write_address,
                              out_ch.write_data, out_ch.af_value, out_ch.bc_value,
                              out_ch.de_value, out_ch.hl_value, out_ch.ix_value,
                              out_ch.iy_value});
    end
  end

  // Watchdog: count cycles in which no item moves on either side.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d results outstanding",
               quiet_cycles, tracker.pending());
      $display("cpu_exchange_block_move_search_unit_test: errors");
      $finish;
    end
  end

  // Result receiver. Drop ready in short random bursts while idling is on,
  // and once for a long stretch on request so the unit fills and backs up.
  initial begin
    int hold_left;
    hold_left    = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready  = 1'b0;
        hold_left     = LONG_HOLD - 1;
      end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        hold_left    = $urandom_range(0, 2);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Build an instruction item; fill the fields it ignores with noise.
  function automatic cebms_pkg::in_item_t mk_exec(logic [7:0] b0, logic [7:0] b1,
                                                  logic [7:0] lo, logic [7:0] hi);
    cebms_pkg::in_item_t it;
    it              = cebms_pkg::in_item_t'(53'({$urandom, $urandom}));
    it.opcode       = cebms_pkg::KIND_EXEC;
    it.prefix_byte  = b0;
    it.second_byte  = b1;
    it.read_byte_lo = lo;
    it.read_byte_hi = hi;
    return it;
  endfunction

  function automatic cebms_pkg::in_item_t mk_load(logic [3:0] idx, logic [15:0] value);
    cebms_pkg::in_item_t it;
    it            = cebms_pkg::in_item_t'(53'({$urandom, $urandom}));
    it.opcode     = cebms_pkg::KIND_LOAD;
    it.pair_index = idx;
    it.pair_value = value;
    return it;
  endfunction

  // Offer one item and hold it until the unit takes it. Enter and leave on
  // a falling edge; optionally idle a few cycles first.
  task automatic offer_item(cebms_pkg::in_item_t it);
    if (tx_idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_ch.valid        = 1'b1;
    in_ch.opcode       = it.opcode;
    in_ch.prefix_byte  = it.prefix_byte;
    in_ch.second_byte  = it.second_byte;
    in_ch.read_byte_lo = it.read_byte_lo;
    in_ch.read_byte_hi = it.read_byte_hi;
    in_ch.pair_index   = it.pair_index;
    in_ch.pair_value   = it.pair_value;
    do @(posedge clk); while (!in_ch.ready);
    items_offered++;
    @(negedge clk);
  endtask

  // Stop sending and wait until every queued result has come back, then
  // let the pipeline settle.
  task automatic drain();
    in_ch.valid = 1'b0;
    while (tracker.pending() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // Write the stack pointer; only call with the unit idle.
  task automatic write_sp(logic [15:0] value);
    cfg_wr_en     = 1'b1;
    cfg_wr_data   = value;
    tracker.sp_reg = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  // Load a small counter, then issue one block instruction repeatedly, the
  // way a CPU re-issues a repeat form until it reports a nonzero advance.
  task automatic block_burst();
    logic [15:0] count;
    logic [7:0]  op2;
    logic [7:0]  lo;
    int          reps;
    count = 16'($urandom_range(0, 5));
    if ($urandom_range(0, 3) == 0)
      offer_item(mk_load(cebms_pkg::PAIR_HL, 16'($urandom)));
    if ($urandom_range(0, 3) == 0)
      offer_item(mk_load(cebms_pkg::PAIR_DE, 16'($urandom)));
    if ($urandom_range(0, 4) == 0)
      offer_item(mk_load(cebms_pkg::PAIR_AF, 16'($urandom)));
    offer_item(mk_load(cebms_pkg::PAIR_BC, count));
    op2 = cebms_pkg::BLK_MATCH | (8'($urandom) & ~cebms_pkg::BLK_MASK);
    op2[cebms_pkg::BLK_BIT_REPEAT] = ($urandom_range(0, 3) != 0);
    reps = (count == 16'd0) ? $urandom_range(1, 6) : int'(count) + $urandom_range(0, 1);
    repeat (reps) begin
      lo = ($urandom_range(0, 3) == 0) ? tracker.accumulator() : 8'($urandom);
      offer_item(mk_exec(cebms_pkg::PFX_ED, op2, lo, 8'($urandom)));
    end
  endtask

  // One random item from the mix: loads, exchanges, stack exchanges and
  // noise, with prefixes favored so near misses of the decoder show up.
  task automatic random_item();
    cebms_pkg::in_item_t it;
    int       pick;
    logic [7:0] b0;
    pick = $urandom_range(0, 99);
    if (pick < 25) begin
      it = mk_load(4'($urandom_range(0, 9)), 16'($urandom));
      if ($urandom_range(0, 7) == 0) it.pair_index = 4'($urandom);
      if ($urandom_range(0, 3) == 0) it.pair_value = 16'($urandom_range(0, 2));
      if ($urandom_range(0, 7) == 0) it.pair_value = 16'hFFFF;
    end else if (pick < 45) begin
      case ($urandom_range(0, 2))
        0:       b0 = cebms_pkg::OP_EX_DE_HL;
        1:       b0 = cebms_pkg::OP_EX_AF_AF;
        default: b0 = cebms_pkg::OP_EXX;
      endcase
      it = mk_exec(b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end else if (pick < 65) begin
      case ($urandom_range(0, 2))
        0:       b0 = cebms_pkg::OP_EX_SP_HL;
        1:       b0 = cebms_pkg::PFX_IX;
        default: b0 = cebms_pkg::PFX_IY;
      endcase
      it = mk_exec(b0, cebms_pkg::OP_EX_SP_HL, 8'($urandom), 8'($urandom));
    end else begin
      it = mk_exec(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      case ($urandom_range(0, 3))
        0: it.prefix_byte = cebms_pkg::PFX_ED;
        1: it.prefix_byte = ($urandom_range(0, 1) == 0) ? cebms_pkg::PFX_IX
                                                        : cebms_pkg::PFX_IY;
        default: ;
      endcase
    end
    offer_item(it);
  endtask

  task automatic random_phase(int n);
    int start;
    start = items_offered;
    while (items_offered - start < n) begin
      if ($urandom_range(0, 1) == 0) block_burst();
      else random_item();
    end
  endtask

  // Edge values, every instruction form and the documented corner cases.
  task automatic directed_phase();
    offer_item(mk_load(cebms_pkg::PAIR_AF, 16'h5AFF));
    offer_item(mk_load(cebms_pkg::PAIR_BC, 16'h0000));
    offer_item(mk_load(cebms_pkg::PAIR_DE, 16'hFFFF));
    offer_item(mk_load(cebms_pkg::PAIR_HL, 16'h0000));
    offer_item(mk_load(cebms_pkg::PAIR_IX, 16'hFFFF));
    offer_item(mk_load(cebms_pkg::PAIR_IY, 16'h8000));
    // pair indices past IY load nothing
    offer_item(mk_load(4'd10, 16'h1234));
    offer_item(mk_load(4'd15, 16'hFFFF));
    offer_item(mk_exec(cebms_pkg::OP_EX_DE_HL, 8'h00, 8'h00, 8'h00));
    offer_item(mk_exec(cebms_pkg::OP_EX_AF_AF, 8'h00, 8'h00, 8'h00));
    // alternate counter is zero after this, so the next repeat wraps BC
    offer_item(mk_exec(cebms_pkg::OP_EXX, 8'hFF, 8'hFF, 8'hFF));
    offer_item(mk_exec(cebms_pkg::OP_EX_SP_HL, 8'h00, 8'hFF, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_IX, cebms_pkg::OP_EX_SP_HL, 8'h00, 8'hFF));
    offer_item(mk_exec(cebms_pkg::PFX_IY, cebms_pkg::OP_EX_SP_HL, 8'h34, 8'h12));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h10, 8'hFF, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h18, 8'h00, 8'h00));
    // counter runs out on a single step
    offer_item(mk_load(cebms_pkg::PAIR_BC, 16'h0001));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH, 8'h80, 8'h00));
    // repeat search that stops on a match
    offer_item(mk_load(cebms_pkg::PAIR_BC, 16'h0005));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h11,
                       tracker.accumulator(), 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h19, 8'h0F, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h01, 8'hFF, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h09, 8'h01, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, cebms_pkg::BLK_MATCH | 8'h08, 8'h7E, 8'h00));
    // unknown opcodes leave everything untouched
    offer_item(mk_exec(8'h00, 8'h00, 8'h00, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_ED, 8'hA2, 8'h00, 8'h00));
    offer_item(mk_exec(cebms_pkg::PFX_IX, 8'h00, 8'h00, 8'h00));
  endtask

  initial begin
    // Drive every input to a known value before the first edge.
    rst_n              = 1'b0;
    cfg_wr_en          = 1'b0;
    cfg_wr_data        = '0;
    in_ch.valid        = 1'b0;
    in_ch.opcode       = 1'b0;
    in_ch.prefix_byte  = '0;
    in_ch.second_byte  = '0;
    in_ch.read_byte_lo = '0;
    in_ch.read_byte_hi = '0;
    in_ch.pair_index   = '0;
    in_ch.pair_value   = '0;
    items_offered      = 0;
    quiet_cycles       = 0;
    tx_idle_en         = 1'b0;
    rx_idle_en         = 1'b0;
    long_hold_req      = 1'b0;

    // Hold reset, then release it on a falling edge.
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part with idling on both sides and the top stack address.
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
    write_sp(16'hFFFF);
    directed_phase();
    drain();

    // Back-pressure: the receiver holds off while the sender keeps offering.
    write_sp(16'h0000);
    tx_idle_en    = 1'b0;
    long_hold_req = 1'b1;
    random_phase(200);
    drain();

    tx_idle_en = 1'b1;
    write_sp(16'($urandom));
    random_phase(300);
    drain();

    write_sp(16'h8000);
    random_phase(300);
    drain();

    // Last stretch at full rate, no idling anywhere.
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    write_sp(16'($urandom));
    random_phase(200);
    drain();

    $display("run covered %0d items: %0d pair loads, %0d stack exchanges,",
             items_offered, tracker.n_loads, tracker.n_stack);
    $display("  %0d repeat steps still running, %0d unrecognized, %0d results checked",
             tracker.n_repeats, tracker.n_unknown, tracker.n_checked);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("cpu_exchange_block_move_search_unit_test: clean");
    end else begin
      $display("cpu_exchange_block_move_search_unit_test: errors");
    end
    $finish;
  end

endmodule
